// ----- rtl/core/scaled_overlay_alpha_blend_unit_assert.svh -----
// ---------------------------------------------------------------------------
// scaled overlay alpha blend unit - assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef SCALED_OVERLAY_ALPHA_BLEND_UNIT_ASSERT_SVH
`define SCALED_OVERLAY_ALPHA_BLEND_UNIT_ASSERT_SVH

// same-cycle implication
`define SOAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soab port check failed");

// implication after a fixed number of cycles
`define SOAB_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("soab latency check failed");

`endif

// ----- rtl/core/soab_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soab_pkg
// types, constants and helpers of the scaled overlay alpha blend unit
// ---------------------------------------------------------------------------
package soab_pkg;

  // field widths
  localparam int BAR_W      = 11;
  localparam int TEX_W      = 7;
  localparam int FILL_W     = 17;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 32;
  localparam int IDX_W      = 12;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  // scaling datapath
  localparam int PROD_W     = 17;   // coord * tex size
  localparam int DIV_W      = 18;   // remainder and shifted divisor
  localparam int Q_W        = 7;    // quotient bits, quotient below tex size
  localparam int ADDR_SUM_W = 17;   // row * tex_width + col, wide enough for any row and column quotient

  // pipeline stage indexes
  localparam int ST_PROD    = 1;
  localparam int ST_DIV_END = ST_PROD + Q_W;
  localparam int ST_ADDR    = ST_DIV_END + 1;
  localparam int ST_MEM     = ST_ADDR + 1;
  localparam int N_ST       = ST_MEM + 1;
  // edges from request accept to result accept
  localparam int PIPE_LATENCY = N_ST + 1;

  // constants
  localparam logic [BAR_W-1:0]  BAR_MAX      = 11'd1024;
  localparam logic [FILL_W-1:0] FILL_ONE     = 17'd65536;
  localparam logic [7:0]        FG_WEIGHT    = 8'd141;   // 0.55 in q8
  localparam logic [7:0]        BG_WEIGHT    = 8'd115;   // 1 - 0.55 in q8
  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
  localparam logic [BAR_W-1:0]  BAR_RESET    = 11'd1;
  localparam logic [TEX_W-1:0]  TEX_RESET    = 7'd1;

  typedef enum logic [0:0] {
    OP_LOAD      = 1'b0,
    OP_COMPOSITE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_BAR_WIDTH  = 3'd0,
    REG_BAR_HEIGHT = 3'd1,
    REG_TEX_WIDTH  = 3'd2,
    REG_TEX_HEIGHT = 3'd3,
    REG_FILL_LEVEL = 3'd4
  } cfg_reg_e;

  // payload that travels down the pipeline
  typedef struct packed {
    opcode_e            op;
    logic [IDX_W-1:0]   idx;
    logic [PIX_W-1:0]   data;   // texel for loads, background for composites
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               inb;    // pixel lies in the drawn part of the bar
  } pipe_t;

  function automatic logic [7:0] mix_channel(input logic [7:0] fg, input logic [7:0] bg);
    logic [15:0] acc;
    acc = 16'(fg) * 16'(FG_WEIGHT) + 16'(bg) * 16'(BG_WEIGHT);
    return acc[15:8];
  endfunction

endpackage

// ----- rtl/core/soab_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soab_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module soab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/scaled_overlay_alpha_blend_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scaled_overlay_alpha_blend_unit
// fill-level bar overlay: texel store, nearest-neighbour scaling, 0.55 blend
// ---------------------------------------------------------------------------
// usage
//   config: apb-style port, registers at byte address 4*i: bar_width,
//     bar_height, tex_width, tex_height, fill_level (unsigned q16).
//     write only while no request is in flight.
//   request: taken at a clock edge with start high; busy stays low, the
//     pipeline never holds off. opcode load writes texel_value into the
//     texel store at texel_index, composite blends one screen pixel.
//   result: one per composite request, none per load. done_o is high for
//     exactly one cycle with write_pixel_o, pixel_color_o, out_x_o, out_y_o.
//     the receiver cannot stall, so nothing ever waits in the output stage.
//   pipeline: a request passes the capture, product, divider, address and
//     texel stages and the output register before done_o rises; the 7-step
//     column/row divider sets most of that depth.
//   throughput: one request every cycle, loads and composites mixed freely.
//   reset: clears valid bits and config to their reset values; the texel
//     store is not cleared and must be loaded before it is read.
//   TEXEL_DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module scaled_overlay_alpha_blend_unit
  import soab_pkg::*;
#(
  parameter int TEXEL_DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                opcode_i,
  input  logic [IDX_W-1:0]    texel_index_i,
  input  logic [PIX_W-1:0]    texel_value_i,
  input  logic [COORD_W-1:0]  pixel_x_i,
  input  logic [COORD_W-1:0]  pixel_y_i,
  input  logic [PIX_W-1:0]    background_pixel_i,
  // result channel
  output logic                done_o,
  output logic                write_pixel_o,
  output logic [PIX_W-1:0]    pixel_color_o,
  output logic [COORD_W-1:0]  out_x_o,
  output logic [COORD_W-1:0]  out_y_o
);

  localparam int AW = $clog2(TEXEL_DEPTH);

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [BAR_W-1:0]  bar_width_q, bar_height_q;
  logic [TEX_W-1:0]  tex_width_q, tex_height_q;
  logic [FILL_W-1:0] fill_level_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_width_q  <= BAR_RESET;
      bar_height_q <= BAR_RESET;
      tex_width_q  <= TEX_RESET;
      tex_height_q <= TEX_RESET;
      fill_level_q <= FILL_ONE;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[4:2]))
        REG_BAR_WIDTH:  bar_width_q  <= pwdata[BAR_W-1:0];
        REG_BAR_HEIGHT: bar_height_q <= pwdata[BAR_W-1:0];
        REG_TEX_WIDTH:  tex_width_q  <= pwdata[TEX_W-1:0];
        REG_TEX_HEIGHT: tex_height_q <= pwdata[TEX_W-1:0];
        REG_FILL_LEVEL: fill_level_q <= pwdata[FILL_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[4:2]))
      REG_BAR_WIDTH:  prdata = CFG_DW'(bar_width_q);
      REG_BAR_HEIGHT: prdata = CFG_DW'(bar_height_q);
      REG_TEX_WIDTH:  prdata = CFG_DW'(tex_width_q);
      REG_TEX_HEIGHT: prdata = CFG_DW'(tex_height_q);
      REG_FILL_LEVEL: prdata = CFG_DW'(fill_level_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // derived bar geometry, refreshed every cycle from the config registers
  // ---------------------------------------------------------------------------
  logic [BAR_W-1:0]        bw_sat_d, bh_sat_d, bw_sat_q, bh_sat_q;
  logic [FILL_W-1:0]       fill_sat;
  logic [BAR_W+FILL_W-1:0] drawn_prod;
  logic [BAR_W-1:0]        drawn_d, drawn_q;
  logic                    bar_nz_q;

  always_comb begin
    bw_sat_d   = (bar_width_q  > BAR_MAX) ? BAR_MAX : bar_width_q;
    bh_sat_d   = (bar_height_q > BAR_MAX) ? BAR_MAX : bar_height_q;
    fill_sat   = (fill_level_q > FILL_ONE) ? FILL_ONE : fill_level_q;
    // bar width times q16 fill, integer part; never exceeds the width
    drawn_prod = (BAR_W+FILL_W)'(bw_sat_d) * (BAR_W+FILL_W)'(fill_sat);
    drawn_d    = drawn_prod[BAR_W+15:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_sat_q <= BAR_RESET;
      bh_sat_q <= BAR_RESET;
      drawn_q  <= BAR_RESET;
      bar_nz_q <= 1'b1;
    end else begin
      bw_sat_q <= bw_sat_d;
      bh_sat_q <= bh_sat_d;
      drawn_q  <= drawn_d;
      bar_nz_q <= (bw_sat_d != '0) && (bh_sat_d != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // request intake and valid chain
  // ---------------------------------------------------------------------------
  logic        req_accept;
  logic        valid_q [N_ST];
  pipe_t       pipe_q  [N_ST];

  assign busy       = 1'b0;   // never stalls, one request per cycle
  assign req_accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ST; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= req_accept;
      for (int i = 1; i < N_ST; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // stage 0: capture the request, one data word serves both opcodes
  always_ff @(posedge clk_i) begin
    pipe_q[0].op   <= opcode_e'(opcode_i);
    pipe_q[0].idx  <= texel_index_i;
    pipe_q[0].data <= (opcode_e'(opcode_i) == OP_LOAD) ? texel_value_i : background_pixel_i;
    pipe_q[0].x    <= pixel_x_i;
    pipe_q[0].y    <= pixel_y_i;
    pipe_q[0].inb  <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stage 1: bounds test and scale products
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0] rx_q [Q_W];   // column dividend / partial remainder
  logic [DIV_W-1:0] ry_q [Q_W];   // row dividend / partial remainder
  logic [Q_W-1:0]   qx_q [Q_W+1]; // column quotient, msb first
  logic [Q_W-1:0]   qy_q [Q_W+1]; // row quotient, msb first
  pipe_t            prod_d;

  always_comb begin
    prod_d     = pipe_q[0];
    prod_d.inb = bar_nz_q
                 && (BAR_W'(pipe_q[0].x) < drawn_q)
                 && (BAR_W'(pipe_q[0].y) < bh_sat_q);
  end

  always_ff @(posedge clk_i) begin
    pipe_q[ST_PROD] <= prod_d;
    rx_q[0] <= DIV_W'(PROD_W'(pipe_q[0].x) * PROD_W'(tex_width_q));
    ry_q[0] <= DIV_W'(PROD_W'(pipe_q[0].y) * PROD_W'(tex_height_q));
    qx_q[0] <= '0;
    qy_q[0] <= '0;
  end

  // ---------------------------------------------------------------------------
  // stages 2..8: restoring divide, one quotient bit per stage
  // dividend is below divisor*128 whenever the pixel is in bounds
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    localparam int K = Q_W - 1 - s;
    logic [DIV_W-1:0] dx, dy;
    logic             gex, gey;

    assign dx  = DIV_W'(bw_sat_q) << K;
    assign dy  = DIV_W'(bh_sat_q) << K;
    assign gex = rx_q[s] >= dx;
    assign gey = ry_q[s] >= dy;

    always_ff @(posedge clk_i) begin
      pipe_q[ST_PROD+s+1] <= pipe_q[ST_PROD+s];
      qx_q[s+1]           <= {qx_q[s][Q_W-2:0], gex};
      qy_q[s+1]           <= {qy_q[s][Q_W-2:0], gey};
    end

    if (s < Q_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rx_q[s+1] <= gex ? (rx_q[s] - dx) : rx_q[s];
        ry_q[s+1] <= gey ? (ry_q[s] - dy) : ry_q[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: texel address; loads and reads meet the store at the same
  // stage so request order is kept
  // ---------------------------------------------------------------------------
  logic [ADDR_SUM_W-1:0] addr_sum, load_addr;
  logic [AW-1:0]         mem_addr_q;
  logic                  mem_we_q;
  logic [PIX_W-1:0]      mem_rdata;

  always_comb begin
    addr_sum  = ADDR_SUM_W'(qy_q[Q_W]) * ADDR_SUM_W'(tex_width_q)
              + ADDR_SUM_W'(qx_q[Q_W]);
    load_addr = ADDR_SUM_W'(pipe_q[ST_DIV_END].idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_we_q <= 1'b0;
    end else begin
      // loads past the end of the store are dropped
      mem_we_q <= valid_q[ST_DIV_END] && (pipe_q[ST_DIV_END].op == OP_LOAD)
                  && (load_addr < ADDR_SUM_W'(TEXEL_DEPTH));
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[ST_ADDR] <= pipe_q[ST_DIV_END];
    // texel address wraps modulo the store depth
    mem_addr_q      <= (pipe_q[ST_DIV_END].op == OP_LOAD) ? load_addr[AW-1:0]
                                                          : addr_sum[AW-1:0];
  end

  soab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TEXEL_DEPTH)
  ) u_texel_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we_q),
    .waddr_i (mem_addr_q),
    .wdata_i (pipe_q[ST_ADDR].data),
    .raddr_i (mem_addr_q),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 10: texel arrives; blend and register the result
  // ---------------------------------------------------------------------------
  logic             done_d, write_d;
  logic [PIX_W-1:0] color_d;
  logic             done_q, write_pixel_q;
  logic [PIX_W-1:0] pixel_color_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;

  always_ff @(posedge clk_i) begin
    pipe_q[ST_MEM] <= pipe_q[ST_ADDR];
  end

  always_comb begin
    done_d  = valid_q[ST_MEM] && (pipe_q[ST_MEM].op == OP_COMPOSITE);
    // transparent texels leave the screen pixel alone
    write_d = pipe_q[ST_MEM].inb && (mem_rdata[7:0] != 8'd0);
    color_d = write_d ? {mix_channel(mem_rdata[31:24], pipe_q[ST_MEM].data[31:24]),
                         mix_channel(mem_rdata[23:16], pipe_q[ST_MEM].data[23:16]),
                         mix_channel(mem_rdata[15:8],  pipe_q[ST_MEM].data[15:8]),
                         ALPHA_OPAQUE}
                      : pipe_q[ST_MEM].data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    write_pixel_q <= write_d;
    pixel_color_q <= color_d;
    out_x_q       <= pipe_q[ST_MEM].x;
    out_y_q       <= pipe_q[ST_MEM].y;
  end

  assign done_o        = done_q;
  assign write_pixel_o = write_pixel_q;
  assign pixel_color_o = pixel_color_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;

endmodule

// ----- rtl/core/soab_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soab_checker
// port-level checks of the scaled overlay alpha blend unit
// ---------------------------------------------------------------------------
`include "scaled_overlay_alpha_blend_unit_assert.svh"

module soab_checker
  import soab_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic               opcode_i,
  input logic [COORD_W-1:0] pixel_x_i,
  input logic [COORD_W-1:0] pixel_y_i,
  input logic [PIX_W-1:0]   background_pixel_i,
  input logic               done_i,
  input logic               write_pixel_i,
  input logic [PIX_W-1:0]   pixel_color_i,
  input logic [COORD_W-1:0] out_x_i,
  input logic [COORD_W-1:0] out_y_i
);

  logic comp_req, load_req;

  assign comp_req = start_i && !busy_i && (opcode_e'(opcode_i) == OP_COMPOSITE);
  assign load_req = start_i && !busy_i && (opcode_e'(opcode_i) == OP_LOAD);

  // every composite request gives a result after the pipeline depth
  `SOAB_ASSERT_AFTER(a_comp_result, clk_i, rst_ni, comp_req, PIPE_LATENCY, done_i)

  // a load never produces a result in its slot
  `SOAB_ASSERT_AFTER(a_load_silent, clk_i, rst_ni, load_req, PIPE_LATENCY, !done_i)

  // written pixels are opaque
  `SOAB_ASSERT_NOW(a_opaque, clk_i, rst_ni, done_i && write_pixel_i, pixel_color_i[7:0] == ALPHA_OPAQUE)

  // unwritten pixels echo the background of their request
  `SOAB_ASSERT_NOW(a_bg_echo, clk_i, rst_ni, done_i && !write_pixel_i, pixel_color_i == $past(background_pixel_i, PIPE_LATENCY))

  // coordinates echo the request's position
  `SOAB_ASSERT_NOW(a_xy_echo, clk_i, rst_ni, done_i, (out_x_i == $past(pixel_x_i, PIPE_LATENCY)) && (out_y_i == $past(pixel_y_i, PIPE_LATENCY)))

endmodule

bind scaled_overlay_alpha_blend_unit soab_checker u_soab_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start),
  .busy_i             (busy),
  .opcode_i           (opcode_i),
  .pixel_x_i          (pixel_x_i),
  .pixel_y_i          (pixel_y_i),
  .background_pixel_i (background_pixel_i),
  .done_i             (done_o),
  .write_pixel_i      (write_pixel_o),
  .pixel_color_i      (pixel_color_o),
  .out_x_i            (out_x_o),
  .out_y_i            (out_y_o)
);
